FILE: rtl/dpad_last_pressed_resolver_macros.svh
// Assertion macros for the direction-pad resolver
`ifndef DPAD_LAST_PRESSED_RESOLVER_MACROS_SVH
`define DPAD_LAST_PRESSED_RESOLVER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define DPLR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dplr assertion failed");
// next-cycle implication, disabled in reset
`define DPLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dplr assertion failed");
`else
`define DPLR_ASSERT_NOW(lbl, ante, cons)
`define DPLR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/dplr_pkg.sv
// Shared constants, types and direction map for the direction-pad resolver
`timescale 1ns / 1ps
package dplr_pkg;

  localparam int MAX_HELD = 8;
  localparam int CNT_W    = $clog2(MAX_HELD + 1);
  localparam int CODE_W   = 8;
  localparam int DIR_W    = 4;

  localparam logic [DIR_W-1:0] DIR_NEUTRAL    = 4'd0;
  localparam logic [DIR_W-1:0] DIR_UP         = 4'd1;
  localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd3;
  localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd4;
  localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd5;
  localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd6;
  localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd7;
  localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd8;

  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // event broadcast to every cell
  typedef struct packed {
    logic              valid;
    logic              release_ev;
    logic [CODE_W-1:0] code;
  } dplr_ev_t;

  // per-slot position flags derived from the fill count
  typedef struct packed {
    logic live;     // slot holds a held button
    logic tail;     // slot is the append position
    logic top2;     // slot is one of the two newest entries
  } dplr_slot_t;

  function automatic logic [DIR_W-1:0] dir_of(input logic [CODE_W-1:0] v);
    logic [DIR_W-1:0] d;
    unique case (v)
      8'h01:   d = DIR_UP;
      8'h02:   d = DIR_RIGHT;
      8'h03:   d = DIR_UP_RIGHT;
      8'h04:   d = DIR_DOWN;
      8'h06:   d = DIR_DOWN_RIGHT;
      8'h08:   d = DIR_LEFT;
      8'h09:   d = DIR_UP_LEFT;
      8'h0C:   d = DIR_DOWN_LEFT;
      default: d = DIR_NEUTRAL;   // opposing or unknown combination
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/dplr_cell.sv
// One slot of the held-button list: stores a code, matches, shifts and appends
`timescale 1ns / 1ps
module dplr_cell
  import dplr_pkg::*;
(
  input  logic              clk,
  input  dplr_ev_t          ev,
  input  dplr_slot_t        slot,
  input  logic              found,     // code matched somewhere in the list
  input  logic              seen_in,   // match in a lower slot
  input  logic [CODE_W-1:0] nbr_code,  // code of the next-newer slot
  output logic              seen_out,
  output logic [CODE_W-1:0] code_o,
  output logic [CODE_W-1:0] or_o
);

  logic [CODE_W-1:0] code_r;
  logic [CODE_W-1:0] code_nxt;
  logic              hit;

  assign hit      = slot.live && (code_r == ev.code);
  assign seen_out = seen_in || hit;

  always_comb begin
    code_nxt = code_r;
    if (ev.valid) begin
      // release: this slot and everything above the match takes its neighbour
      if (ev.release_ev && seen_out) begin
        code_nxt = nbr_code;
      end else if (!ev.release_ev && slot.tail && !found) begin
        code_nxt = ev.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign code_o = code_r;
  assign or_o   = slot.top2 ? code_r : '0;

endmodule

FILE: rtl/dpad_last_pressed_resolver.sv
// Top level of the direction-pad resolver: cell row, fill count and result stage
//
// Usage:
//   Input: drive in_cmd (0 press, 1 release) and in_button with start high;
//   the beat is taken at a rising edge where start is high and busy is low.
//   busy is always low: the cell row updates every slot at once, so a
//   new event may be given every clock.
//   Output: out_valid is high for exactly one cycle per event, with
//   out_direction holding the hat direction after that event. There is no
//   back-pressure on the output; the receiver must take every beat.
//   Result path: the cells and pend_r take the event at the accepting edge;
//   the next edge registers the OR of the two newest codes mapped to a
//   direction into out_direction_r and copies pend_r into out_valid_r.
//   Throughput: one event per cycle, as the cell row never holds off an event.
//   Reset (rst_n low, synchronous) empties the list and drops any result
//   in flight; stored codes are left as they are and never read while empty.
`timescale 1ns / 1ps
`include "dpad_last_pressed_resolver_macros.svh"
module dpad_last_pressed_resolver
  import dplr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [CODE_W-1:0] in_button,
  output logic              out_valid,
  output logic [DIR_W-1:0]  out_direction
);

  logic                acc;
  dplr_ev_t            ev;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                pend_r;
  logic                out_valid_r;
  logic [DIR_W-1:0]    out_direction_r;
  logic [MAX_HELD:0]   seen;
  logic [CODE_W-1:0]   codes [MAX_HELD];
  logic [CODE_W-1:0]   ors   [MAX_HELD];
  logic [MAX_HELD-1:0] hits;
  logic [CODE_W-1:0]   or_all;
  logic                found;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign ev.valid      = acc;
  assign ev.release_ev = (in_cmd == CMD_RELEASE);
  assign ev.code       = in_button;

  assign seen[0] = 1'b0;
  assign found   = seen[MAX_HELD];

  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    dplr_slot_t        slot;
    logic [CODE_W-1:0] nbr;

    assign slot.live = CNT_W'(i) < count_r;
    assign slot.tail = CNT_W'(i) == count_r;
    assign slot.top2 = slot.live &&
                       (({1'b0, count_r} == (CNT_W+1)'(i + 1)) ||
                        ({1'b0, count_r} == (CNT_W+1)'(i + 2)));

    if (i == MAX_HELD - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = codes[i+1];
    end

    dplr_cell u_cell (
      .clk      (clk),
      .ev       (ev),
      .slot     (slot),
      .found    (found),
      .seen_in  (seen[i]),
      .nbr_code (nbr),
      .seen_out (seen[i+1]),
      .code_o   (codes[i]),
      .or_o     (ors[i])
    );

    assign hits[i] = seen[i+1] && !seen[i];
  end

  always_comb begin
    or_all = '0;
    for (int k = 0; k < MAX_HELD; k++) begin
      or_all = or_all | ors[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (acc) begin
      if (ev.release_ev && found) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (!ev.release_ev && !found && (count_r < CNT_W'(MAX_HELD))) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= acc;
      out_valid_r <= pend_r;
    end
  end

  // list state settles at the accepting edge; its direction is registered here
  always_ff @(posedge clk) begin
    out_direction_r <= dir_of(or_all);
  end

  assign out_valid     = out_valid_r;
  assign out_direction = out_direction_r;

  `DPLR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_HELD))
  `DPLR_ASSERT_NOW(a_no_dup, 1'b1, $onehot0(hits))
  `DPLR_ASSERT_NEXT(a_dup_press, acc && !ev.release_ev && found, count_r == $past(count_r))
  `DPLR_ASSERT_NEXT(a_release, acc && ev.release_ev && found,
                    count_r == $past(count_r) - CNT_W'(1))
  `DPLR_ASSERT_NEXT(a_empty_neutral, pend_r && (count_r == '0),
                    out_direction_r == DIR_NEUTRAL)

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the direction-pad resolver (directed table, then random events)
`timescale 1ns / 1ps
module tb_top;
  import dplr_pkg::*;

  localparam int RANDOM_BEATS = 1000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_cmd = CMD_PRESS;
  logic [CODE_W-1:0] in_button = '0;
  logic              out_valid;
  logic [DIR_W-1:0]  out_direction;

  dpad_last_pressed_resolver DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_button    (in_button),
    .out_valid    (out_valid),
    .out_direction(out_direction)
  );

  // directed stimulus row; pinned rows carry a hand-typed direction
  typedef struct {
    logic              cmd;
    logic [CODE_W-1:0] button;
    bit                pinned;
    logic [DIR_W-1:0]  dir;
  } dpad_row_t;

  dpad_row_t         dpad_rows[$];
  logic [DIR_W-1:0]  dir_expected_q[$];
  logic [CODE_W-1:0] held_codes[MAX_HELD];
  int                held_num;
  int                mismatch_count;
  int                cycle_count;
  logic [DIR_W-1:0]  dir_want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // tracks the press-ordered held list and returns the hat direction after the event
  function automatic logic [DIR_W-1:0] apply_held_event(logic cmd, logic [CODE_W-1:0] code);
    int                pos;
    logic [CODE_W-1:0] merged;
    logic [DIR_W-1:0]  dir;
    pos = -1;
    for (int i = 0; i < held_num; i++)
      if (pos < 0 && held_codes[i] == code) pos = i;
    if (cmd == CMD_PRESS) begin
      if (pos < 0 && held_num < MAX_HELD) begin
        held_codes[held_num] = code;
        held_num++;
      end
    end else if (pos >= 0) begin
      for (int i = pos; i < held_num - 1; i++) held_codes[i] = held_codes[i + 1];
      held_num--;
    end
    merged = '0;
    if (held_num >= 1) merged |= held_codes[held_num - 1];
    if (held_num >= 2) merged |= held_codes[held_num - 2];
    case (merged)
      8'h01:   dir = DIR_UP;
      8'h02:   dir = DIR_RIGHT;
      8'h03:   dir = DIR_UP_RIGHT;
      8'h04:   dir = DIR_DOWN;
      8'h06:   dir = DIR_DOWN_RIGHT;
      8'h08:   dir = DIR_LEFT;
      8'h09:   dir = DIR_UP_LEFT;
      8'h0C:   dir = DIR_DOWN_LEFT;
      default: dir = DIR_NEUTRAL;
    endcase
    return dir;
  endfunction

  // mostly real direction codes, some odd ones, some fully random
  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    logic [CODE_W-1:0] odd_codes[4];
    odd_codes = '{8'h00, 8'h10, 8'h80, 8'h03};
    r = $urandom_range(99);
    if (r < 70) return CODE_W'(1) << $urandom_range(3);
    if (r < 85) return odd_codes[$urandom_range(3)];
    return CODE_W'($urandom_range(255));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result beats cannot be held off: each strobe is taken at the edge ending its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (dir_expected_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat: direction %0d", out_direction);
        mismatch_count++;
      end else begin
        dir_want = dir_expected_q.pop_front();
        if (out_direction !== dir_want) begin
          if (mismatch_count < 10)
            $display("direction mismatch: expected %0d, got %0d", dir_want, out_direction);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int                n;
    int                gap;
    int                idle_pct;
    logic              cmd;
    logic [CODE_W-1:0] code;
    logic [DIR_W-1:0]  dir;
    bit                pinned;

    cycle_count    = 0;
    mismatch_count = 0;
    held_num       = 0;
    foreach (held_codes[i]) held_codes[i] = '0;

    dpad_rows.push_back('{CMD_PRESS,   8'h01, 1'b1, DIR_UP});      // first press after reset
    dpad_rows.push_back('{CMD_PRESS,   8'h02, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_PRESS,   8'h01, 1'b0, DIR_NEUTRAL}); // duplicate press
    dpad_rows.push_back('{CMD_RELEASE, 8'h01, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h01, 1'b0, DIR_NEUTRAL}); // release of absent code
    dpad_rows.push_back('{CMD_PRESS,   8'h04, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_PRESS,   8'h08, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_PRESS,   8'h01, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_PRESS,   8'h04, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h08, 1'b1, DIR_NEUTRAL}); // up with down: opposing
    dpad_rows.push_back('{CMD_PRESS,   8'h00, 1'b0, DIR_NEUTRAL}); // code zero takes a slot but adds no bits
    dpad_rows.push_back('{CMD_PRESS,   8'hFF, 1'b1, DIR_NEUTRAL}); // unknown pattern
    dpad_rows.push_back('{CMD_PRESS,   8'h80, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_PRESS,   8'h40, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_PRESS,   8'h10, 1'b0, DIR_NEUTRAL}); // list now full
    dpad_rows.push_back('{CMD_PRESS,   8'h20, 1'b0, DIR_NEUTRAL}); // press when full
    dpad_rows.push_back('{CMD_RELEASE, 8'hFF, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h10, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h80, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h40, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h00, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h02, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h04, 1'b0, DIR_NEUTRAL});
    dpad_rows.push_back('{CMD_RELEASE, 8'h01, 1'b1, DIR_NEUTRAL}); // back to empty

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n = 0;
    while (n < dpad_rows.size() + RANDOM_BEATS) begin
      if (n < dpad_rows.size()) begin
        cmd    = dpad_rows[n].cmd;
        code   = dpad_rows[n].button;
        pinned = dpad_rows[n].pinned;
        dir    = dpad_rows[n].dir;
        gap    = 0;
      end else begin
        pinned = 1'b0;
        dir    = DIR_NEUTRAL;
        cmd    = ($urandom_range(99) < 55) ? CMD_PRESS : CMD_RELEASE;
        if (cmd == CMD_RELEASE && held_num > 0 && $urandom_range(3) != 0)
          code = held_codes[$urandom_range(held_num - 1)];
        else
          code = pick_code();
        // sender idling: light, then heavy, then none; each cycle idles with idle_pct odds
        if (n < dpad_rows.size() + RANDOM_BEATS / 3) idle_pct = 22;
        else if (n < dpad_rows.size() + 2 * RANDOM_BEATS / 3) idle_pct = 64;
        else idle_pct = 0;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
      end

      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      start     <= 1'b1;
      in_cmd    <= cmd;
      in_button <= code;
      do @(posedge clk); while (busy);

      // beat taken at this edge
      if (pinned) begin
        void'(apply_held_event(cmd, code));
        dir_expected_q.push_back(dir);
      end else begin
        dir_expected_q.push_back(apply_held_event(cmd, code));
      end
      n++;
    end
    start <= 1'b0;

    while (dir_expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && dir_expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/dplr_pkg.sv
rtl/dplr_cell.sv
rtl/dpad_last_pressed_resolver.sv
dv/tb_top.sv
